@@ rtl/fpa_pkg.sv @@
// Fixed partition allocator: shared types, codes and reset constants.
// No dependencies.
package fpa_pkg;

   localparam int NUM_PARTS_DEF = 4;
   localparam int MAX_PARTS     = 8;
   localparam int NUM_REGS      = 4;
   localparam int REG_IDX_W     = 2;
   localparam int SIZE_W        = 16;
   localparam int PID_W         = 16;
   localparam int PART_IDX_W    = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_REGS] =
      '{16'd100, 16'd50, 16'd75, 16'd30};

   typedef enum logic [1:0] {
      CMD_FIRST = 2'd0,
      CMD_BEST  = 2'd1,
      CMD_WORST = 2'd2,
      CMD_FREE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_ALLOC   = 2'd0,
      STAT_NOFIT   = 2'd1,
      STAT_FREED   = 2'd2,
      STAT_NOOWNER = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_REPLY = 2'd2
   } state_type;

endpackage

@@ rtl/fixed_partition_allocator.sv @@
// Fixed partition allocator top level: scan sequencer, partition table, csr.
// Depends on fpa_pkg.
//
// Usage:
//  - A request (req_command, req_process_id, req_request_size) is taken at a
//    rising edge with start high and busy low. Commands: first, best or worst
//    fit allocate, or free by owner.
//  - One compare unit walks the partitions, one per cycle, from partition 0.
//    First fit and free stop at the first hit; best and worst fit visit all
//    NUM_PARTS partitions.
//  - The response shows on rsp_status / rsp_part_index for exactly one cycle
//    with rsp_valid high, once the scan has ended.
//    busy is high from the cycle after start until the response cycle ends,
//    so the scan length sets how long one request takes.
//  - The receiver cannot stall; the response is lost if not taken.
//  - csr_write_en writes csr_wdata to the size register csr_index at once;
//    write only while busy is low.
//  - Reset (synchronous) frees all partitions and loads the default sizes.
module fixed_partition_allocator
   import fpa_pkg::*;
#(
   parameter int NUM_PARTS = NUM_PARTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [PID_W-1:0]      req_process_id,
   input  logic [SIZE_W-1:0]     req_request_size,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [PART_IDX_W-1:0] rsp_part_index,
   input  logic                  csr_write_en,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic                  found_ff, found_in;
   logic [SIZE_W-1:0]     pick_size_ff, pick_size_in;
   cmd_type               cmd_ff, cmd_in;
   logic [PID_W-1:0]      pid_ff, pid_in;
   logic [SIZE_W-1:0]     req_size_ff, req_size_in;
   logic [NUM_PARTS-1:0]  occupied_ff, occupied_in;
   logic [SIZE_W-1:0]     part_size_ff [NUM_REGS];
   logic [PID_W-1:0]      owner_ff [NUM_PARTS];
   logic                  owner_we;

   logic [PART_IDX_W-1:0] idx_ext;
   logic [SIZE_W-1:0]     cur_size;
   logic                  last_part;
   logic                  fit;
   logic                  owner_hit;
   logic                  take;
   logic                  scan_done;
   logic                  is_free;

   // current partition under the compare unit
   always_comb begin
      idx_ext   = PART_IDX_W'(idx_ff);
      cur_size  = (idx_ext < PART_IDX_W'(NUM_REGS)) ? part_size_ff[idx_ext[REG_IDX_W-1:0]]
                                                    : '0;
      last_part = (idx_ff == IDX_W'(NUM_PARTS - 1));
      is_free   = (cmd_ff == CMD_FREE);
      fit       = !occupied_ff[idx_ff] && (cur_size >= req_size_ff);
      owner_hit = occupied_ff[idx_ff] && (owner_ff[idx_ff] == pid_ff);
      take      = fit && (!found_ff
                          || ((cmd_ff == CMD_BEST)  && (cur_size < pick_size_ff))
                          || ((cmd_ff == CMD_WORST) && (cur_size > pick_size_ff)));
      scan_done = last_part || (is_free && owner_hit)
                  || ((cmd_ff == CMD_FIRST) && fit);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) begin
            state_in = ST_SCAN;
         end
         ST_SCAN:  if (scan_done) begin
            state_in = ST_REPLY;
         end
         ST_REPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      found_in     = found_ff;
      pick_size_in = pick_size_ff;
      cmd_in       = cmd_ff;
      pid_in       = pid_ff;
      req_size_in  = req_size_ff;
      occupied_in  = occupied_ff;
      owner_we     = 1'b0;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd_in       = cmd_type'(req_command);
               pid_in       = req_process_id;
               req_size_in  = req_request_size;
               idx_in       = '0;
               pick_in      = '0;
               found_in     = 1'b0;
               pick_size_in = '0;
            end
         end
         ST_SCAN: begin
            if (is_free ? owner_hit : take) begin
               found_in     = 1'b1;
               pick_in      = idx_ff;
               pick_size_in = cur_size;
            end
            if (!last_part) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_REPLY: begin
            rsp_valid = 1'b1;
            if (found_ff) begin
               occupied_in[pick_ff] = !is_free;
               owner_we             = !is_free;
            end
         end
         default: busy = 1'b0;
      endcase
      if (found_ff) begin
         rsp_status     = is_free ? STAT_FREED : STAT_ALLOC;
         rsp_part_index = PART_IDX_W'(pick_ff);
      end else begin
         rsp_status     = is_free ? STAT_NOOWNER : STAT_NOFIT;
         rsp_part_index = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         occupied_ff <= '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            part_size_ff[i] <= SIZE_RESET[i];
         end
      end else begin
         state_ff    <= state_in;
         occupied_ff <= occupied_in;
         if (csr_write_en) begin
            part_size_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pick_ff      <= pick_in;
      found_ff     <= found_in;
      pick_size_ff <= pick_size_in;
      cmd_ff       <= cmd_in;
      pid_ff       <= pid_in;
      req_size_ff  <= req_size_in;
      if (owner_we) begin
         owner_ff[pick_ff] <= pid_ff;
      end
   end

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("response not followed by idle");

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request taken without entering scan");

   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_NOFIT || rsp_status == STAT_NOOWNER))
      |-> (rsp_part_index == '0))
      else $error("failure response with nonzero index");

   a_alloc_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_ALLOC) |=> occupied_ff[$past(pick_ff)])
      else $error("allocated partition not marked occupied");

endmodule
